[hw/rtl/sample_covariance_variance_assert.svh]
// Assertion macros used by the covariance block checker.
`ifndef SAMPLE_COVARIANCE_VARIANCE_ASSERT_SVH
`define SAMPLE_COVARIANCE_VARIANCE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SCV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/scv_pkg.sv]
// Types and fixed constants of the sample covariance and variance block.
package scv_pkg;

  localparam int unsigned BESSEL_W  = 16;
  localparam int unsigned COV_W     = 56;
  localparam int unsigned VAR_W     = 55;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned STATUS_W  = 2;

  // Result tdata layout, lowest bit first.
  localparam int unsigned COV_LSB   = 0;
  localparam int unsigned VAR_A_LSB = COV_LSB + COV_W;
  localparam int unsigned VAR_B_LSB = VAR_A_LSB + VAR_W;
  localparam int unsigned COUNT_LSB = VAR_B_LSB + VAR_W;
  localparam int unsigned RES_BITS  = COUNT_LSB + COUNT_W;
  localparam int unsigned M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_DIV   = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SEL_COV,
    SEL_VAR_A,
    SEL_VAR_B
  } stat_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AB,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_CHECK,
    ST_DEN,
    ST_PROD_N,
    ST_PROD_S,
    ST_ABS,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } scv_state_e;

endpackage

[hw/rtl/sample_covariance_variance.sv]
// Streaming covariance and variance of paired samples over a data set.
//
// Input stream: tdata carries sample_a and sample_b, tlast marks the final
// pair of a data set. While the count is below MAX_COUNT, each request is
// accepted and its samples added in ST_IDLE, then ST_MUL_AB, ST_MUL_AA and
// ST_MUL_BB form the products a*b, a*a and b*b through one shared
// SAMPLE_BITS x SAMPLE_BITS multiplier. tready is high only while idle.
// After the last pair a sequencer drives one shared NUM_W-bit add/subtract
// unit: shift-add multiplies for N*(N-d), N*Sxy and Sx*Sy, then a restoring
// divide one quotient bit per cycle. An error result skips these steps.
// Output stream: tdata carries covariance, variance_a, variance_b and
// pair_count; tuser carries the status. The result sits in an output
// register, so new pairs are taken while it waits; a finished result of the
// next data set holds until that register is free. Accumulators clear as a
// result leaves for the output register.
// Reset clears all sums and the count and sets bessel_subtrahend to 1.
// The configuration write lands at any clock edge with cfg_wr_en_i high.
module sample_covariance_variance
  import scv_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_COUNT   = 65536,
  parameter int unsigned FRAC_BITS   = 8,
  localparam int unsigned S_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [BESSEL_W-1:0]  cfg_wr_data_i,   // bessel_subtrahend
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // sample_a, sample_b
  input  logic                 s_axis_tlast_i,  // last_pair
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // covariance, variance_a, variance_b, pair_count
  output logic [STATUS_W-1:0]  m_axis_tuser_o   // status
);

  localparam int unsigned CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned PROD_W = 2 * SAMPLE_BITS;
  localparam int unsigned SQ_W   = PROD_W + CNT_W - 1;
  localparam int unsigned NUM_W  = 2 * SUM_W;
  localparam int unsigned DEN_W  = 2 * CNT_W;
  localparam int unsigned MAG_W  = NUM_W + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(MAG_W);
  localparam int unsigned CMP_W  = (BESSEL_W > CNT_W) ? BESSEL_W : CNT_W;
  localparam int unsigned EXT_W  = (MAG_W > COV_W + 1) ? MAG_W : COV_W + 1;
  localparam logic [EXT_W-1:0] POS_LIM = (EXT_W'(1) << VAR_W) - EXT_W'(1);
  localparam logic [EXT_W-1:0] NEG_LIM = EXT_W'(1) << VAR_W;

  scv_state_e state_q, state_d;
  stat_sel_e  sel_q, sel_nxt, setup_sel;
  status_e    res_status_q, out_status_q;

  logic [BESSEL_W-1:0]           bessel_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          ovf_q;
  logic                          last_q;
  logic signed [SAMPLE_BITS-1:0] a_q, b_q, in_a, in_b, mul_x, mul_y;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0]       sum_a_q, sum_b_q, sx_cur, sy_cur;
  logic signed [SQ_W-1:0]        sum_ab_q, sum_aa_q, sum_bb_q, sxy_setup;

  logic [STEP_W-1:0] step_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    rem_sh;
  logic [NUM_W-1:0]  num_q, mcand_q;
  logic [SUM_W-1:0]  mplier_q;
  logic [MAG_W-1:0]  mag_q;
  logic              neg_q;

  logic [NUM_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub;

  logic             in_acc, at_max, step_done, bessel_ge, out_free, take;
  logic [CNT_W-1:0] n_minus_bs;

  logic [EXT_W-1:0] q_ext, pos_sat, neg_mag, neg_val;
  logic [COV_W-1:0] cov_sat;
  logic [VAR_W-1:0] var_sat;

  logic [COV_W-1:0]   res_cov_q, out_cov_q;
  logic [VAR_W-1:0]   res_va_q, res_vb_q, out_va_q, out_vb_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               m_valid_q;

  assign in_a       = s_axis_tdata_i[SAMPLE_BITS-1:0];
  assign in_b       = s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign at_max     = (cnt_q == CNT_W'(MAX_COUNT));
  assign step_done  = (step_q == '0);
  assign bessel_ge  = (CMP_W'(bessel_q) >= CMP_W'(cnt_q));
  assign n_minus_bs = CNT_W'(CMP_W'(cnt_q) - CMP_W'(bessel_q));
  assign out_free   = !m_valid_q || m_axis_tready_i;

  // Shared units: one small multiplier for the per-pair products and one
  // wide adder for every multiply step and divide step of the final pass.
  assign prod    = PROD_W'(mul_x) * PROD_W'(mul_y);
  assign alu_res = alu_a + (alu_b ^ {NUM_W{alu_sub}}) + NUM_W'(alu_sub);

  assign rem_sh = {rem_q, mag_q[MAG_W-1]};
  assign take   = !alu_res[NUM_W-1];

  always_comb begin
    sel_nxt = SEL_COV;
    case (sel_q)
      SEL_COV:   sel_nxt = SEL_VAR_A;
      SEL_VAR_A: sel_nxt = SEL_VAR_B;
      default:   sel_nxt = SEL_COV;
    endcase
  end

  assign setup_sel = (state_q == ST_STORE) ? sel_nxt : sel_q;

  always_comb begin
    sx_cur = sum_a_q;
    sy_cur = sum_b_q;
    case (sel_q)
      SEL_COV:   begin sx_cur = sum_a_q; sy_cur = sum_b_q; end
      SEL_VAR_A: begin sx_cur = sum_a_q; sy_cur = sum_a_q; end
      SEL_VAR_B: begin sx_cur = sum_b_q; sy_cur = sum_b_q; end
      default:   ;
    endcase
  end

  always_comb begin
    sxy_setup = sum_ab_q;
    case (setup_sel)
      SEL_COV:   sxy_setup = sum_ab_q;
      SEL_VAR_A: sxy_setup = sum_aa_q;
      SEL_VAR_B: sxy_setup = sum_bb_q;
      default:   ;
    endcase
  end

  // Clamp the quotient magnitude to the output ranges.
  assign q_ext   = EXT_W'(mag_q);
  assign pos_sat = (q_ext > POS_LIM) ? POS_LIM : q_ext;
  assign neg_mag = (q_ext > NEG_LIM) ? NEG_LIM : q_ext;
  assign neg_val = '0 - neg_mag;
  assign cov_sat = neg_q ? neg_val[COV_W-1:0] : pos_sat[COV_W-1:0];
  assign var_sat = neg_q ? '0 : pos_sat[VAR_W-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (at_max) begin
            state_d = s_axis_tlast_i ? ST_CHECK : ST_IDLE;
          end else begin
            state_d = ST_MUL_AB;
          end
        end
      end
      ST_MUL_AB: state_d = ST_MUL_AA;
      ST_MUL_AA: state_d = ST_MUL_BB;
      ST_MUL_BB: state_d = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK:  state_d = (ovf_q || bessel_ge) ? ST_EMIT : ST_DEN;
      ST_DEN: begin
        if (step_done) state_d = ST_PROD_N;
      end
      ST_PROD_N: begin
        if (step_done) state_d = ST_PROD_S;
      end
      ST_PROD_S: begin
        if (step_done) state_d = ST_ABS;
      end
      ST_ABS: state_d = ST_DIV;
      ST_DIV: begin
        if (step_done) state_d = ST_STORE;
      end
      ST_STORE: state_d = (sel_q == SEL_VAR_B) ? ST_EMIT : ST_PROD_N;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Unit operand selection and handshake.
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_x           = a_q;
    mul_y           = b_q;
    alu_a           = num_q;
    alu_b           = '0;
    alu_sub         = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready_o = 1'b1;
      ST_MUL_AA: begin mul_x = a_q; mul_y = a_q; end
      ST_MUL_BB: begin mul_x = b_q; mul_y = b_q; end
      ST_DEN, ST_PROD_N: alu_b = mplier_q[0] ? mcand_q : '0;
      ST_PROD_S: begin
        // sign bit of the multiplier weighs negative: add there, subtract elsewhere
        alu_b   = mplier_q[0] ? mcand_q : '0;
        alu_sub = !step_done;
      end
      ST_ABS: begin
        alu_a   = '0;
        alu_b   = num_q;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = NUM_W'(rem_sh);
        alu_b   = NUM_W'(den_q);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state, configuration and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bessel_q  <= BESSEL_W'(1);
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      sum_ab_q  <= '0;
      sum_aa_q  <= '0;
      sum_bb_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) bessel_q <= cfg_wr_data_i;
      if ((state_q == ST_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (at_max) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q   <= cnt_q + CNT_W'(1);
              sum_a_q <= sum_a_q + SUM_W'(in_a);
              sum_b_q <= sum_b_q + SUM_W'(in_b);
            end
          end
        end
        ST_MUL_AB: sum_ab_q <= sum_ab_q + SQ_W'(prod);
        ST_MUL_AA: sum_aa_q <= sum_aa_q + SQ_W'(prod);
        ST_MUL_BB: sum_bb_q <= sum_bb_q + SQ_W'(prod);
        ST_EMIT: begin
          if (out_free) begin
            cnt_q     <= '0;
            ovf_q     <= 1'b0;
            sum_a_q   <= '0;
            sum_b_q   <= '0;
            sum_ab_q  <= '0;
            sum_aa_q  <= '0;
            sum_bb_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the final pass and the output register.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          a_q    <= in_a;
          b_q    <= in_b;
          last_q <= s_axis_tlast_i;
        end
      end
      ST_CHECK: begin
        res_cov_q <= '0;
        res_va_q  <= '0;
        res_vb_q  <= '0;
        if (ovf_q) begin
          res_status_q <= STATUS_OVERFLOW;
        end else if (bessel_ge) begin
          res_status_q <= STATUS_NO_DIV;
        end else begin
          res_status_q <= STATUS_OK;
        end
        sel_q    <= SEL_COV;
        num_q    <= '0;
        mcand_q  <= NUM_W'(n_minus_bs);
        mplier_q <= SUM_W'(cnt_q);
        step_q   <= STEP_W'(CNT_W - 1);
      end
      ST_DEN: begin
        if (step_done) begin
          den_q    <= alu_res[DEN_W-1:0];
          num_q    <= '0;
          mcand_q  <= NUM_W'(sxy_setup);
          mplier_q <= SUM_W'(cnt_q);
          step_q   <= STEP_W'(CNT_W - 1);
        end else begin
          num_q    <= alu_res;
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          step_q   <= step_q - STEP_W'(1);
        end
      end
      ST_PROD_N: begin
        num_q <= alu_res;
        if (step_done) begin
          mcand_q  <= NUM_W'(sy_cur);
          mplier_q <= sx_cur;
          step_q   <= STEP_W'(SUM_W - 1);
        end else begin
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          step_q   <= step_q - STEP_W'(1);
        end
      end
      ST_PROD_S: begin
        num_q    <= alu_res;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        step_q   <= step_q - STEP_W'(1);
      end
      ST_ABS: begin
        neg_q  <= num_q[NUM_W-1];
        mag_q  <= MAG_W'(num_q[NUM_W-1] ? alu_res : num_q) << FRAC_BITS;
        rem_q  <= '0;
        step_q <= STEP_W'(MAG_W - 1);
      end
      ST_DIV: begin
        // restoring divide: keep the difference when it does not go negative
        rem_q  <= take ? alu_res[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        mag_q  <= {mag_q[MAG_W-2:0], take};
        step_q <= step_q - STEP_W'(1);
      end
      ST_STORE: begin
        case (sel_q)
          SEL_COV:   res_cov_q <= cov_sat;
          SEL_VAR_A: res_va_q  <= var_sat;
          SEL_VAR_B: res_vb_q  <= var_sat;
          default:   ;
        endcase
        sel_q    <= sel_nxt;
        num_q    <= '0;
        mcand_q  <= NUM_W'(sxy_setup);
        mplier_q <= SUM_W'(cnt_q);
        step_q   <= STEP_W'(CNT_W - 1);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_cov_q    <= res_cov_q;
          out_va_q     <= res_va_q;
          out_vb_q     <= res_vb_q;
          out_cnt_q    <= COUNT_W'(cnt_q);
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = M_TDATA_W'({out_cnt_q, out_vb_q, out_va_q, out_cov_q});
  assign m_axis_tuser_o  = out_status_q;

endmodule

[hw/rtl/scv_checker.sv]
// Port-level checks of the covariance block, bound to its top level.
`include "sample_covariance_variance_assert.svh"

module scv_checker
  import scv_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 s_axis_tlast_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [STATUS_W-1:0]  m_axis_tuser_o
);

  // The last pair of a set always starts work, so the next cycle is busy.
  `SCV_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o, "ready after last pair")

  // An error result carries zero values.
  `SCV_ASSERT_NOW(a_error_zero_values, m_axis_tvalid_o && (m_axis_tuser_o != STATUS_OK), m_axis_tdata_o[COUNT_LSB-1:0] == '0, "nonzero values with error status")

  `SCV_ASSERT_NEXT(a_result_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind sample_covariance_variance scv_checker u_scv_checker (.*);
